// ===== rtl/core/sor_poisson_grid_solver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sor_poisson_grid_solver_unit_assert.svh
// Assertion macros for the SOR Poisson grid solver unit
// ----------------------------------------------------------------------------
`ifndef SOR_POISSON_GRID_SOLVER_UNIT_ASSERT_SVH
`define SOR_POISSON_GRID_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPGS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spgs_pkg.sv =====
// ----------------------------------------------------------------------------
// spgs_pkg
// Shared constants, codes and types of the SOR Poisson grid solver
// ----------------------------------------------------------------------------
package spgs_pkg;

  // grid store geometry
  localparam int ROW_MAX = 128;
  localparam int COL_MAX = 256;
  localparam int ROW_W   = $clog2(ROW_MAX);
  localparam int COL_W   = $clog2(COL_MAX);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int CELLS   = ROW_MAX * COL_MAX;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_OMEGA    = 3'd0;
  localparam logic [2:0] CFG_MAX_ITER = 3'd1;
  localparam logic [2:0] CFG_TOL_SQ   = 3'd2;
  localparam logic [2:0] CFG_ROWS     = 3'd3;
  localparam logic [2:0] CFG_COLS     = 3'd4;

  // register reset values
  localparam logic [14:0] OMEGA_RST    = 15'd29491;
  localparam logic [15:0] MAX_ITER_RST = 16'd100;
  localparam logic [7:0]  ROWS_RST     = 8'd126;
  localparam logic [8:0]  COLS_RST     = 9'd253;

  // residual limits
  localparam logic [62:0]        SUM_MAX = {63{1'b1}};
  localparam logic signed [33:0] R_LIMIT = 34'sd3037000499;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_SWEEP_CHK,
    ST_RD_U,
    ST_RD_UP,
    ST_RD_DN,
    ST_RD_LF,
    ST_RD_RT,
    ST_CAP,
    ST_RES,
    ST_MUL,
    ST_APPLY,
    ST_SWEEP_END
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = {r, c};
  endfunction

endpackage

// ===== rtl/core/spgs_ram.sv =====
// ----------------------------------------------------------------------------
// spgs_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module spgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sor_poisson_grid_solver_unit.sv =====
// ----------------------------------------------------------------------------
// sor_poisson_grid_solver_unit
// 2D Poisson solver by successive over-relaxation on a stored grid
// ----------------------------------------------------------------------------
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+--------------------
//  input   | in_operation in_row in_col in_source_value | start, busy
//  result  | out_cell_value out_iterations out_residual_sq out_converged
//          |                                           | out_valid strobe
//  config  | cfg_index cfg_data                        | cfg_we
//
//  load: result beat on the next cycle; read: the cell is captured in the
//  response state, then the result beat follows. solve: a clearing pass over
//  the solution memory, then per sweep an update pass and a residual pass
//  over the grid, each cell paced by one solution memory read port and the
//  shared multiplier. after reset the same clearing pass runs with busy high.
//  the result beat cannot be stalled; busy is high for the whole solve.
// ----------------------------------------------------------------------------
`include "sor_poisson_grid_solver_unit_assert.svh"

module sor_poisson_grid_solver_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [6:0]          in_row,
  input  logic [7:0]          in_col,
  input  logic signed [31:0]  in_source_value,
  output logic                out_valid,
  output logic signed [31:0]  out_cell_value,
  output logic [15:0]         out_iterations,
  output logic [62:0]         out_residual_sq,
  output logic                out_converged,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [62:0]         cfg_data
);
  import spgs_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic [14:0] omega_r;
  logic [15:0] max_it_r;
  logic [62:0] tol_r;
  logic [7:0]  rows_r;
  logic [8:0]  cols_r;

  // sequencer and datapath registers
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic                  solve_r;
  logic                  phase_res_r;
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_r;
  logic [ROW_W:0]        nr_r;
  logic [COL_W:0]        nc_r;
  logic signed [31:0]    u_r;
  logic signed [35:0]    acc_r;
  logic signed [33:0]    res_r;
  logic                  lim_r;
  logic signed [69:0]    prod_r;
  logic [62:0]           sum_r;
  logic [15:0]           sweep_cnt_r;
  logic [62:0]           resid_r;
  logic                  conv_r;
  logic                  inside_r;
  logic                  out_valid_r;
  logic signed [31:0]    out_cell_r;

  // memory ports
  logic              sol_we;
  logic [ADDR_W-1:0] sol_waddr;
  logic [31:0]       sol_wdata;
  logic [ADDR_W-1:0] sol_raddr;
  logic [31:0]       sol_rdata;
  logic              src_we;
  logic [31:0]       src_rdata;

  logic accept;
  logic in_inside;
  logic last_row, last_col;
  logic dn_ok, rt_ok;
  logic signed [35:0] rd_ext;
  logic signed [35:0] u_ext;
  logic signed [69:0] prod_nxt;
  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [36:0] res_sum;
  logic signed [36:0] res_shift;
  logic signed [69:0] d_full;
  logic signed [36:0] upd_sum;
  logic signed [31:0] upd_sat;
  logic [63:0]        sum_add;
  logic [ROW_W:0]     nr_clamp;
  logic [COL_W:0]     nc_clamp;

  assign accept    = start && (state_r == ST_IDLE);
  assign in_inside = (32'(in_row) < ROW_MAX) && (32'(in_col) < COL_MAX);
  assign last_row  = (row_r == ROW_W'(nr_r - 1'b1));
  assign last_col  = (col_r == COL_W'(nc_r - 1'b1));
  assign dn_ok     = ((ROW_W+1)'(row_r) + 1'b1) < nr_r;
  assign rt_ok     = ((COL_W+1)'(col_r) + 1'b1) < nc_r;
  assign rd_ext    = 36'(signed'(sol_rdata));
  assign u_ext     = 36'(u_r);

  // grid size clamp
  always_comb begin
    if (rows_r < 8'd2) begin
      nr_clamp = (ROW_W+1)'(2);
    end else if (32'(rows_r) > ROW_MAX) begin
      nr_clamp = (ROW_W+1)'(ROW_MAX);
    end else begin
      nr_clamp = (ROW_W+1)'(rows_r);
    end
    if (cols_r < 9'd2) begin
      nc_clamp = (COL_W+1)'(2);
    end else if (32'(cols_r) > COL_MAX) begin
      nc_clamp = (COL_W+1)'(COL_MAX);
    end else begin
      nc_clamp = (COL_W+1)'(cols_r);
    end
  end

  // shared multiplier operands: omega times a, or residual squared
  always_comb begin
    if (phase_res_r) begin
      mul_a = 36'(res_r);
      mul_b = res_r;
    end else begin
      mul_a = acc_r;
      mul_b = signed'({19'd0, omega_r});
    end
    prod_nxt = 70'(mul_a) * 70'(mul_b);
  end

  // residual rounding, update rounding and saturation
  always_comb begin
    res_sum   = 37'(acc_r) + 37'sd2;
    res_shift = res_sum >>> 2;
    d_full    = (prod_r + 70'sd32768) >>> 16;
    upd_sum   = 37'(u_r) + 37'(signed'(d_full[35:0]));
    if (upd_sum > 37'sd2147483647) begin
      upd_sat = 32'sh7fffffff;
    end else if (upd_sum < -37'sd2147483648) begin
      upd_sat = 32'sh80000000;
    end else begin
      upd_sat = upd_sum[31:0];
    end
    sum_add = {1'b0, sum_r} + {1'b0, prod_r[62:0]};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == {ADDR_W{1'b1}}) begin
          state_nxt = solve_r ? ST_SWEEP_CHK : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_SOLVE: state_nxt = ST_CLEAR;
            OP_READ:  state_nxt = ST_RESP;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RESP:      state_nxt = ST_IDLE;
      ST_SWEEP_CHK: state_nxt = (sweep_cnt_r < max_it_r) ? ST_RD_U : ST_IDLE;
      ST_RD_U:      state_nxt = ST_RD_UP;
      ST_RD_UP:     state_nxt = ST_RD_DN;
      ST_RD_DN:     state_nxt = ST_RD_LF;
      ST_RD_LF:     state_nxt = ST_RD_RT;
      ST_RD_RT:     state_nxt = ST_CAP;
      ST_CAP:       state_nxt = phase_res_r ? ST_RES : ST_MUL;
      ST_RES:       state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_APPLY;
      ST_APPLY: begin
        if (last_row && last_col && phase_res_r) begin
          state_nxt = ST_SWEEP_END;
        end else begin
          state_nxt = ST_RD_U;
        end
      end
      ST_SWEEP_END: begin
        state_nxt = (sum_r <= tol_r) ? ST_IDLE : ST_SWEEP_CHK;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    sol_we    = 1'b0;
    sol_waddr = cell_addr(row_r, col_r);
    sol_wdata = upd_sat;
    sol_raddr = cell_addr(row_r, col_r);
    src_we    = accept && (in_operation == OP_LOAD) && in_inside;
    case (state_r)
      ST_CLEAR: begin
        sol_we    = 1'b1;
        sol_waddr = clr_cnt_r;
        sol_wdata = 32'd0;
      end
      ST_IDLE:  sol_raddr = cell_addr(in_row[ROW_W-1:0], in_col[COL_W-1:0]);
      ST_RD_UP: sol_raddr = cell_addr(row_r - 1'b1, col_r);
      ST_RD_DN: sol_raddr = cell_addr(row_r + 1'b1, col_r);
      ST_RD_LF: sol_raddr = cell_addr(row_r, col_r - 1'b1);
      ST_RD_RT: sol_raddr = cell_addr(row_r, col_r + 1'b1);
      ST_APPLY: sol_we    = !phase_res_r;
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r  <= OMEGA_RST;
      max_it_r <= MAX_ITER_RST;
      tol_r    <= '0;
      rows_r   <= ROWS_RST;
      cols_r   <= COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OMEGA:    omega_r  <= cfg_data[14:0];
        CFG_MAX_ITER: max_it_r <= cfg_data[15:0];
        CFG_TOL_SQ:   tol_r    <= cfg_data;
        CFG_ROWS:     rows_r   <= cfg_data[7:0];
        CFG_COLS:     cols_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      solve_r     <= 1'b0;
      phase_res_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      sweep_cnt_r <= '0;
      resid_r     <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_cnt_r <= clr_cnt_r + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            if (in_operation == OP_SOLVE) begin
              solve_r     <= 1'b1;
              clr_cnt_r   <= '0;
              sweep_cnt_r <= '0;
              resid_r     <= '0;
              conv_r      <= 1'b0;
            end else if (in_operation != OP_READ) begin
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_RESP: out_valid_r <= 1'b1;
        ST_SWEEP_CHK: begin
          phase_res_r <= 1'b0;
          row_r       <= '0;
          col_r       <= '0;
          if (sweep_cnt_r >= max_it_r) begin
            out_valid_r <= 1'b1;
            solve_r     <= 1'b0;
          end
        end
        ST_APPLY: begin
          if (last_row) begin
            row_r <= '0;
            if (last_col) begin
              col_r       <= '0;
              phase_res_r <= 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        ST_SWEEP_END: begin
          sweep_cnt_r <= sweep_cnt_r + 1'b1;
          resid_r     <= sum_r;
          if (sum_r <= tol_r) begin
            conv_r      <= 1'b1;
            out_valid_r <= 1'b1;
            solve_r     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        inside_r <= in_inside;
        nr_r     <= nr_clamp;
        nc_r     <= nc_clamp;
        if (accept) begin
          out_cell_r <= '0;
        end
      end
      ST_RESP:      out_cell_r <= inside_r ? signed'(sol_rdata) : 32'sd0;
      ST_SWEEP_CHK: sum_r <= '0;
      ST_RD_UP: begin
        u_r   <= signed'(sol_rdata);
        acc_r <= -(36'(signed'(sol_rdata)) <<< 2) - 36'(signed'(src_rdata));
      end
      ST_RD_DN: acc_r <= acc_r + ((row_r != '0) ? rd_ext : 36'sd0);
      ST_RD_LF: acc_r <= acc_r + (dn_ok ? rd_ext : 36'sd0);
      ST_RD_RT: acc_r <= acc_r + ((col_r != '0) ? rd_ext : u_ext);
      ST_CAP:   acc_r <= acc_r + (rt_ok ? rd_ext : u_ext);
      ST_RES: begin
        res_r <= res_shift[33:0];
        lim_r <= (res_shift > 37'(R_LIMIT)) || (res_shift < -37'(R_LIMIT));
      end
      ST_MUL:   prod_r <= prod_nxt;
      ST_APPLY: begin
        if (phase_res_r) begin
          if (lim_r || sum_add[63]) begin
            sum_r <= SUM_MAX;
          end else begin
            sum_r <= sum_add[62:0];
          end
        end
      end
      default: ;
    endcase
  end

  spgs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_sol_ram (
    .clk   (clk),
    .we    (sol_we),
    .waddr (sol_waddr),
    .wdata (sol_wdata),
    .raddr (sol_raddr),
    .rdata (sol_rdata)
  );

  spgs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (cell_addr(in_row[ROW_W-1:0], in_col[COL_W-1:0])),
    .wdata (in_source_value),
    .raddr (cell_addr(row_r, col_r)),
    .rdata (src_rdata)
  );

  // ports
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cell_value  = out_cell_r;
  assign out_iterations  = sweep_cnt_r;
  assign out_residual_sq = resid_r;
  assign out_converged   = conv_r;

  // checks
  `SPGS_ASSERT_NEXT(a_solve_goes_busy, start && !busy && (in_operation == OP_SOLVE), busy, "solve not started")
  `SPGS_ASSERT_SAME(a_sweep_in_range, state_r == ST_SWEEP_CHK, sweep_cnt_r <= max_it_r, "sweep count past limit")
  `SPGS_ASSERT_SAME(a_cell_in_grid, state_r == ST_RD_U, ((ROW_W+1)'(row_r) < nr_r) && ((COL_W+1)'(col_r) < nc_r), "cell outside grid")

endmodule
